// ===== design/sfr_pkg.sv =====
// Shared types and constants of the serial frame receiver.
package sfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE   = 2'd1;

  localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hA5;
  localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h5A;

  localparam logic [STATUS_W-1:0] ST_BYTE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic                start_frame;
    logic                start_err;
    logic [STATUS_W-1:0] err_status;
  } sfr_event_t;

endpackage

// ===== design/serial_frame_receiver_top.sv =====
// Top level of the serial frame receiver.
//
// Usage: received bytes enter on the s_ stream, one byte per item. Configuration
// writes set the header byte (index 0) and the tail byte (index 1); the user must
// make them only while the block is idle, as the block does not enforce this.
// Results leave on the m_ stream: tdata carries the frame byte, tlast marks the
// final byte of a frame or an error item, and tuser carries the status (0 frame
// byte, 1 length or checksum mismatch, 2 buffer overflow). An input byte is taken
// without waiting when it causes no result or one error result. When a checksum
// byte completes a good frame of N bytes, each byte is read from the frame buffer
// and then placed in the output register, and the next read waits until the byte
// before it has been placed; the input is held off until the last byte has been
// placed in the output register. An error item waits in a state of its own and is
// placed in the output register once the register is free, holding off the input.
// Reset returns the block to hunting for a header and empties the output
// register; the buffer needs no clearing. When the receiver stalls, the output
// register holds its item and the readout waits; input bytes that cause no result
// are still taken while an item waits at the output.
module serial_frame_receiver_top import sfr_pkg::*; #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,   // rx_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [BYTE_W-1:0]    m_tdata,   // frame_byte
  output logic                 m_tlast,
  output logic [STATUS_W-1:0]  m_tuser    // status
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int CW = $clog2(FRAME_DEPTH + 1);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] rd_data;
  sfr_event_t        ev;
  logic [CW-1:0]     emit_len;
  logic              busy;

  assign s_tready = !busy;

  sfr_ctrl #(
    .FRAME_DEPTH(FRAME_DEPTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .ev       (ev),
    .emit_len (emit_len)
  );

  sfr_store #(
    .FRAME_DEPTH(FRAME_DEPTH),
    .AW         (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  sfr_emit #(
    .AW(AW),
    .CW(CW)
  ) u_emit (
    .clk     (clk),
    .rst     (rst),
    .ev      (ev),
    .emit_len(emit_len),
    .rd_data (rd_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .busy    (busy),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule

// ===== design/sfr_store.sv =====
// Frame buffer: one write port and one registered read port.
module sfr_store import sfr_pkg::*; #(
  parameter int FRAME_DEPTH = 64,
  parameter int AW          = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [FRAME_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/sfr_ctrl.sv =====
// Deframer: header hunt, byte collection, length and checksum check.
module sfr_ctrl import sfr_pkg::*; #(
  parameter int FRAME_DEPTH = 64,
  parameter int AW          = 6,
  parameter int CW          = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [BYTE_W-1:0]    s_tdata,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [BYTE_W-1:0]    wr_data,
  output sfr_event_t           ev,
  output logic [CW-1:0]        emit_len
);

  localparam logic [1:0] PH_HUNT    = 2'd0;
  localparam logic [1:0] PH_COLLECT = 2'd1;
  localparam logic [1:0] PH_CHECK   = 2'd2;

  logic [1:0]        phase, phase_next;
  logic [CW-1:0]     count, count_next;
  logic [BYTE_W-1:0] run_xor, run_xor_next;
  logic [BYTE_W-1:0] len_hi, len_hi_next;
  logic [BYTE_W-1:0] len_lo, len_lo_next;
  logic [BYTE_W-1:0] header_reg, tail_reg;
  logic              full, len_ok, sum_ok;
  logic [15:0]       frame_len;

  always_comb begin
    full      = (count == CW'(FRAME_DEPTH));
    frame_len = {len_hi, (count > CW'(2)) ? len_lo : 8'h00};
    len_ok    = (frame_len == 16'(count));
    sum_ok    = (run_xor == s_tdata);

    phase_next   = phase;
    count_next   = count;
    run_xor_next = run_xor;
    len_hi_next  = len_hi;
    len_lo_next  = len_lo;
    wr_en        = 1'b0;
    wr_addr      = count[AW-1:0];
    wr_data      = s_tdata;
    ev           = '0;
    emit_len     = count + CW'(1);

    if (s_tvalid && s_tready) begin
      unique case (phase)
        PH_COLLECT: begin
          if (full) begin
            ev.start_err  = 1'b1;
            ev.err_status = ST_OVERFLOW;
            phase_next    = PH_HUNT;
          end else begin
            wr_en        = 1'b1;
            count_next   = count + CW'(1);
            run_xor_next = run_xor ^ s_tdata;
            if (s_tdata == tail_reg) begin
              phase_next = PH_CHECK;
            end
          end
        end
        PH_CHECK: begin
          if (full) begin
            ev.start_err  = 1'b1;
            ev.err_status = ST_OVERFLOW;
            phase_next    = PH_HUNT;
          end else begin
            wr_en      = 1'b1;
            count_next = count + CW'(1);
            if (len_ok && sum_ok) begin
              ev.start_frame = 1'b1;
              phase_next     = PH_HUNT;
            end else begin
              run_xor_next  = run_xor ^ s_tdata;
              ev.start_err  = 1'b1;
              ev.err_status = ST_MISMATCH;
              phase_next    = PH_COLLECT;
            end
          end
        end
        default: begin
          phase_next = PH_HUNT;
          if (s_tdata == header_reg) begin
            wr_en        = 1'b1;
            wr_addr      = '0;
            count_next   = CW'(1);
            run_xor_next = s_tdata;
            phase_next   = PH_COLLECT;
          end
        end
      endcase
    end

    if (wr_en && wr_addr == AW'(1)) begin
      len_hi_next = s_tdata;
    end
    if (wr_en && wr_addr == AW'(2)) begin
      len_lo_next = s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      count      <= '0;
      run_xor    <= '0;
      header_reg <= HEADER_RESET;
      tail_reg   <= TAIL_RESET;
    end else begin
      phase   <= phase_next;
      count   <= count_next;
      run_xor <= run_xor_next;
      if (cfg_we && cfg_index == REG_HEADER_BYTE) begin
        header_reg <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_TAIL_BYTE) begin
        tail_reg <= cfg_data;
      end
    end
    len_hi <= len_hi_next;
    len_lo <= len_lo_next;
  end

endmodule

// ===== design/sfr_emit.sv =====
// Result sequencer: puts error items and buffered good frames in the output register.
module sfr_emit import sfr_pkg::*; #(
  parameter int AW = 6,
  parameter int CW = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  sfr_event_t          ev,
  input  logic [CW-1:0]       emit_len,
  input  logic [BYTE_W-1:0]   rd_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  output logic                busy,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [BYTE_W-1:0]   m_tdata,
  output logic                m_tlast,
  output logic [STATUS_W-1:0] m_tuser
);

  localparam logic [1:0] E_IDLE = 2'd0;
  localparam logic [1:0] E_ERR  = 2'd1;
  localparam logic [1:0] E_RUN  = 2'd2;

  logic [1:0]          state;
  logic [CW-1:0]       len;
  logic [CW-1:0]       rd_idx;
  logic                rd_pend;
  logic [STATUS_W-1:0] err_status;
  logic                slot_free;
  logic                issue;
  logic                load;

  always_comb begin
    slot_free = !m_tvalid || m_tready;
    issue     = (state == E_RUN) && !rd_pend && slot_free && (rd_idx != len);
    load      = ((state == E_ERR) && slot_free) || ((state == E_RUN) && rd_pend);
    rd_en     = issue;
    rd_addr   = rd_idx[AW-1:0];
    busy      = (state != E_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= E_IDLE;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !load) begin
        m_tvalid <= 1'b0;
      end
      rd_pend <= issue;
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
      unique case (state)
        E_IDLE: begin
          if (ev.start_frame) begin
            state  <= E_RUN;
            len    <= emit_len;
            rd_idx <= '0;
          end else if (ev.start_err) begin
            state      <= E_ERR;
            err_status <= ev.err_status;
          end
        end
        E_ERR: begin
          if (slot_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= '0;
            m_tlast  <= 1'b1;
            m_tuser  <= err_status;
            state    <= E_IDLE;
          end
        end
        E_RUN: begin
          if (rd_pend) begin
            m_tvalid <= 1'b1;
            m_tdata  <= rd_data;
            m_tlast  <= (rd_idx == len);
            m_tuser  <= ST_BYTE;
            if (rd_idx == len) begin
              state <= E_IDLE;
            end
          end
        end
        default: begin
          state <= E_IDLE;
        end
      endcase
    end
  end

  a_pend_in_run: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> state == E_RUN)
    else $error("read data pending outside of frame readout");

  a_pend_single: assert property (@(posedge clk) disable iff (rst)
    rd_pend |=> !rd_pend)
    else $error("two reads in flight at once");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (ev.start_frame || ev.start_err) |-> state == E_IDLE)
    else $error("new event while results are still being produced");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    state == E_RUN |-> rd_idx <= len)
    else $error("read index ran past the frame length");

endmodule
